### src/wppf_pkg.sv
package wppf_pkg;

  localparam int ENTRY_COUNT_DEF = 16;
  localparam logic [23:0] ADDR_MASK_MIRROR = 24'hf0ffff;
  localparam logic [23:0] ADDR_MASK_24 = 24'hffffff;
  localparam logic [23:0] WIN1_LO = 24'h100000;
  localparam logic [23:0] WIN1_HI = 24'h200000;
  localparam logic [23:0] WIN2_LO = 24'hd00000;
  localparam logic [23:0] WIN2_HI = 24'he00000;
  localparam logic [23:0] MIRROR_OFS = 24'h00ffff;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_SET_EN = 3'd2;
  localparam logic [2:0] OP_FILTER = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTE,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic byte_step;
    logic commit_add;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       last_byte;
  } status_t;

  function automatic logic in_mirror(input logic [23:0] a);
    return (a >= WIN1_LO && a < WIN1_HI) || (a >= WIN2_LO && a < WIN2_HI);
  endfunction

  function automatic logic [23:0] fold_addr(input logic [23:0] a);
    if (a >= WIN1_LO && a < WIN1_HI) return WIN1_LO | (a & MIRROR_OFS);
    if (a >= WIN2_LO && a < WIN2_HI) return WIN2_LO | (a & MIRROR_OFS);
    return a;
  endfunction

  function automatic logic [31:0] size_mask(input logic [1:0] sc);
    case (sc)
      2'd0: return 32'h0000_00ff;
      2'd1: return 32'h0000_ffff;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // Byte k, big endian, of a value n = 1 << sc bytes long.
  function automatic logic [7:0] byte_of(input logic [31:0] v, input logic [1:0] sc,
                                         input logic [1:0] k);
    logic [1:0] sh;
    logic [2:0] n;
    n = 3'd1 << sc;
    sh = 2'(n - 3'd1 - {1'b0, k});
    return 8'(v >> {sh, 3'b000});
  endfunction

endpackage

### src/wppf_ctrl.sv
module wppf_ctrl
  import wppf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  input  status_t stat,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          case (stat.op)
            OP_FILTER: state_next = ST_BYTE;
            OP_ADD: state_next = ST_ADD;
            default: begin
              cmd.finish = 1'b1;
              state_next = ST_DONE;
            end
          endcase
        end
      end
      ST_BYTE: begin
        cmd.byte_step = 1'b1;
        if (stat.last_byte) begin
          state_next = ST_DONE;
        end
      end
      ST_ADD: begin
        cmd.commit_add = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready) else $error("accept while busy");
  a_out_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) != ST_IDLE || $past(cmd.finish))
    else $error("result without work");
  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif

endmodule

### src/wppf_datapath.sv
module wppf_datapath
  import wppf_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     stat,
  input  logic [2:0]  op,
  input  logic [23:0] address,
  input  logic [1:0]  size_code,
  input  logic [1:0]  mode_code,
  input  logic [31:0] data_value,
  input  logic [31:0] old_value,
  input  logic        old_valid,
  input  logic [5:0]  slot,
  input  logic [63:0] new_enables,
  output logic        status,
  output logic [5:0]  entry_index,
  output logic [31:0] filtered_value,
  output logic [63:0] enables_now
);

  logic [ENTRY_COUNT-1:0] e_used, e_mir, e_set;
  logic [23:0] e_base [ENTRY_COUNT];
  logic [1:0]  e_size [ENTRY_COUNT];
  logic [31:0] e_val  [ENTRY_COUNT];
  logic [63:0] enable_bits;

  logic [2:0]  r_op;
  logic [23:0] r_addr;
  logic [1:0]  r_sc, r_mc;
  logic [31:0] r_dv, r_ov;
  logic        r_ovalid;
  logic [1:0]  w_idx;
  logic [7:0]  bytes [4];
  logic        any;

  assign enables_now = enable_bits;
  assign stat.op = op;
  assign stat.last_byte = (w_idx == 2'((3'd1 << r_sc) - 3'd1)) || r_sc == 2'd3;

  // Filter one write byte per cycle against all entries in parallel.
  logic [23:0] wa;
  logic        hit;
  logic [7:0]  hit_byte;
  always_comb begin
    logic [2:0] en;
    logic [23:0] am, ea;
    logic found;
    wa = r_addr + {22'd0, w_idx};
    hit = 1'b0;
    hit_byte = byte_of(r_dv & size_mask(r_sc), r_sc, w_idx);
    for (int e = 0; e < ENTRY_COUNT; e++) begin
      found = 1'b0;
      am = e_mir[e] ? ADDR_MASK_MIRROR : ADDR_MASK_24;
      en = (e_size[e] == 2'd3) ? 3'd4 : (3'd1 << e_size[e]);
      for (int k = 0; k < 4; k++) begin
        ea = e_base[e] + 24'(k);
        if (!found && !hit && e_used[e] && enable_bits[e] && 3'(k) < en &&
            (wa & am) == (ea & am)) begin
          found = 1'b1;
          if (e_set[e]) begin
            hit_byte = byte_of(e_val[e], e_size[e], 2'(k));
          end else if (r_ovalid) begin
            hit_byte = byte_of(r_ov & size_mask(r_sc), r_sc, w_idx);
          end
        end
      end
      if (found) hit = 1'b1;
    end
  end

  // Add lookup.
  logic [23:0] canon;
  logic        mir, add_bad, dup, free_any;
  logic [31:0] mv;
  logic [5:0]  dup_idx, free_idx;
  always_comb begin
    canon = fold_addr(r_addr);
    mir = in_mirror(r_addr);
    mv = r_dv & size_mask(r_sc);
    add_bad = (r_sc == 2'd3) || r_mc[1];
    dup = 1'b0;
    dup_idx = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      if (e_used[i] && e_base[i] == canon && e_mir[i] == mir && e_size[i] == r_sc &&
          e_set[i] == r_mc[0] && e_val[i] == mv) begin
        dup = 1'b1;
        dup_idx = 6'(i);
      end
      if (!e_used[i]) begin
        free_any = 1'b1;
        free_idx = 6'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_used <= '0;
      e_mir <= '0;
      e_set <= '0;
      enable_bits <= '0;
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        e_base[i] <= '0;
        e_size[i] <= '0;
        e_val[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        r_op <= op;
        r_addr <= address;
        r_sc <= size_code;
        r_mc <= mode_code;
        r_dv <= data_value;
        r_ov <= old_value;
        r_ovalid <= old_valid;
        w_idx <= '0;
        any <= 1'b0;
        status <= 1'b0;
        entry_index <= '0;
        filtered_value <= '0;
        case (op)
          OP_REMOVE: begin
            if (32'(slot) < ENTRY_COUNT) begin
              enable_bits[slot] <= 1'b0;
              for (int i = 0; i < ENTRY_COUNT; i++) begin
                if (slot == 6'(i)) begin
                  e_used[i] <= 1'b0;
                  e_mir[i] <= 1'b0;
                  e_set[i] <= 1'b0;
                  e_base[i] <= '0;
                  e_size[i] <= '0;
                  e_val[i] <= '0;
                end
              end
            end
          end
          OP_SET_EN: enable_bits <= new_enables;
          OP_CLEAR: begin
            e_used <= '0;
            e_mir <= '0;
            e_set <= '0;
            enable_bits <= '0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
              e_base[i] <= '0;
              e_size[i] <= '0;
              e_val[i] <= '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd.byte_step) begin
        bytes[w_idx] <= hit_byte;
        w_idx <= w_idx + 2'd1;
        if (stat.last_byte) begin
          if (enable_bits == '0 || r_sc == 2'd3 || !(any || hit)) begin
            filtered_value <= r_dv;
          end else begin
            case (r_sc)
              2'd0: filtered_value <= {24'd0, hit_byte};
              2'd1: filtered_value <= {16'd0, bytes[0], hit_byte};
              default: filtered_value <= {bytes[0], bytes[1], bytes[2], hit_byte};
            endcase
          end
        end
        if (hit) any <= 1'b1;
      end
      if (cmd.commit_add) begin
        if (add_bad) begin
          status <= 1'b1;
        end else if (dup) begin
          entry_index <= dup_idx;
        end else if (free_any) begin
          entry_index <= free_idx;
          enable_bits[free_idx] <= 1'b1;
          for (int i = 0; i < ENTRY_COUNT; i++) begin
            if (free_idx == 6'(i)) begin
              e_used[i] <= 1'b1;
              e_base[i] <= canon;
              e_mir[i] <= mir;
              e_size[i] <= r_sc;
              e_set[i] <= r_mc[0];
              e_val[i] <= mv;
            end
          end
        end else begin
          status <= 1'b1;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_used_enabled_add: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_add && !add_bad && !dup && free_any) |=> enable_bits[$past(free_idx)])
    else $error("added entry not enabled");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_add && add_bad) |=> status && entry_index == '0)
    else $error("reject with index");
  a_step_filter: assert property (@(posedge clk) disable iff (rst)
    cmd.byte_step |-> r_op == OP_FILTER) else $error("byte step outside filter");
`endif

endmodule

### src/write_protect_patch_filter.sv
// Write-protect and patch filter. Each transaction on the slave stream is one
// operation (add, remove, set enable mask, filter write, clear) and yields one
// result transaction. A filtered write steps one write byte (1, 2 or 4) per
// cycle after it is taken, each byte compared against all entries in parallel;
// an add commits in a state of its own and other operations finish as they are
// taken, each then holding its result until it is accepted. One operation is in flight at a time.
module write_protect_patch_filter
  import wppf_pkg::*;
#(
  parameter int ENTRY_COUNT = ENTRY_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // op, address, size_code, mode_code, data_value, old_value, old_valid,
  // slot, new_enables (from bit 0 up), zero padded to 168 bits
  input  logic [167:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status, entry_index, filtered_value, enables_now (from bit 0 up)
  output logic [103:0] m_tdata
);

  cmd_t    cmd;
  status_t stat;
  logic        status;
  logic [5:0]  entry_index;
  logic [31:0] filtered_value;
  logic [63:0] enables_now;

  assign m_tdata = {1'b0, enables_now, filtered_value, entry_index, status};

  wppf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .stat(stat), .cmd(cmd)
  );

  wppf_datapath #(.ENTRY_COUNT(ENTRY_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .op(s_tdata[2:0]), .address(s_tdata[26:3]), .size_code(s_tdata[28:27]),
    .mode_code(s_tdata[30:29]), .data_value(s_tdata[62:31]),
    .old_value(s_tdata[94:63]), .old_valid(s_tdata[95]), .slot(s_tdata[101:96]),
    .new_enables(s_tdata[165:102]),
    .status(status), .entry_index(entry_index), .filtered_value(filtered_value),
    .enables_now(enables_now)
  );

endmodule

### tb/write_protect_patch_filter_tb.sv
`timescale 1ns / 1ps

module write_protect_patch_filter_tb;
  import wppf_pkg::*;

  localparam int NUM_ENTRIES = ENTRY_COUNT_DEF;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]  op;
    logic [23:0] address;
    logic [1:0]  size_code;
    logic [1:0]  mode_code;
    logic [31:0] data_value;
    logic [31:0] old_value;
    logic        old_valid;
    logic [5:0]  slot;
    logic [63:0] new_enables;
  } request_t;

  // Members from the top bit down, so status lands in bit 0.
  typedef struct packed {
    logic [63:0] enables_now;
    logic [31:0] filtered_value;
    logic [5:0]  entry_index;
    logic        status;
  } reply_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [103:0] m_tdata;

  // Shadow copy of the protect table.
  logic        tbl_used [NUM_ENTRIES];
  logic [23:0] tbl_base [NUM_ENTRIES];
  logic        tbl_mirrored [NUM_ENTRIES];
  logic [1:0]  tbl_size [NUM_ENTRIES];
  logic        tbl_set_mode [NUM_ENTRIES];
  logic [31:0] tbl_value [NUM_ENTRIES];
  logic [63:0] tbl_enables;

  reply_t expected_replies[$];
  bit     failed = 1'b0;
  bit     quiet;
  int     cycle_count = 0;
  int     stall_left;

  // Addresses near existing entries make matches frequent.
  logic [23:0] recent_addrs[$];

  write_protect_patch_filter dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic bit window_hit(logic [23:0] a);
    return (a >= WIN1_LO && a < WIN1_HI) || (a >= WIN2_LO && a < WIN2_HI);
  endfunction

  function automatic logic [23:0] canonical(logic [23:0] a);
    if (a >= WIN1_LO && a < WIN1_HI) return WIN1_LO | (a & 24'h00ffff);
    if (a >= WIN2_LO && a < WIN2_HI) return WIN2_LO | (a & 24'h00ffff);
    return a;
  endfunction

  function automatic logic [31:0] width_mask(logic [1:0] sc);
    return (sc == 2'd0) ? 32'hff : (sc == 2'd1) ? 32'hffff : 32'hffffffff;
  endfunction

  function automatic logic [7:0] be_byte(logic [31:0] v, int n, int k);
    return 8'(v >> (((n - 1 - k) & 3) * 8));
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      tbl_used[i] = 1'b0;
      tbl_base[i] = '0;
      tbl_mirrored[i] = 1'b0;
      tbl_size[i] = '0;
      tbl_set_mode[i] = 1'b0;
      tbl_value[i] = '0;
    end
    tbl_enables = '0;
  endfunction

  function automatic logic [31:0] patch_write(request_t r);
    int n;
    logic [31:0] nv;
    logic [31:0] ov;
    logic [7:0] bytes [4];
    logic [31:0] rebuilt;
    logic [23:0] wa;
    logic [23:0] ea;
    logic [23:0] am;
    bit hit;
    bit any;
    int en;
    any = 0;
    rebuilt = '0;
    if (tbl_enables == '0 || r.size_code == 2'd3) return r.data_value;
    n = 1 << r.size_code;
    nv = r.data_value & width_mask(r.size_code);
    ov = r.old_value & width_mask(r.size_code);
    for (int w = 0; w < n; w++) begin
      wa = r.address + 24'(w);
      hit = 0;
      bytes[w] = be_byte(nv, n, w);
      for (int e = 0; e < NUM_ENTRIES && !hit; e++) begin
        if (!tbl_used[e] || !tbl_enables[e]) continue;
        en = 1 << tbl_size[e];
        if (en > 4) en = 4;
        am = tbl_mirrored[e] ? ADDR_MASK_MIRROR : ADDR_MASK_24;
        for (int k = 0; k < en; k++) begin
          ea = tbl_base[e] + 24'(k);
          if ((wa & am) != (ea & am)) continue;
          if (tbl_set_mode[e]) bytes[w] = be_byte(tbl_value[e], en, k);
          else if (r.old_valid) bytes[w] = be_byte(ov, n, w);
          hit = 1;
          break;
        end
      end
      if (hit) any = 1;
    end
    if (!any) return r.data_value;
    for (int w = 0; w < n; w++) rebuilt = (rebuilt << 8) | 32'(bytes[w]);
    return rebuilt;
  endfunction

  function automatic reply_t apply_request(request_t r);
    reply_t rep;
    logic [23:0] canon;
    logic mir;
    logic [31:0] mv;
    bit done;
    rep = '0;
    done = 0;
    case (r.op)
      OP_ADD: begin
        rep.status = 1'b1;
        if (r.size_code <= 2'd2 && r.mode_code <= 2'd1) begin
          canon = canonical(r.address);
          mir = window_hit(r.address);
          mv = r.data_value & width_mask(r.size_code);
          for (int i = 0; i < NUM_ENTRIES && !done; i++)
            if (tbl_used[i] && tbl_base[i] == canon && tbl_mirrored[i] == mir &&
                tbl_size[i] == r.size_code && tbl_set_mode[i] == r.mode_code[0] &&
                tbl_value[i] == mv) begin
              rep.status = 1'b0;
              rep.entry_index = 6'(i);
              done = 1;
            end
          for (int i = 0; i < NUM_ENTRIES && !done; i++)
            if (!tbl_used[i]) begin
              tbl_used[i] = 1'b1;
              tbl_base[i] = canon;
              tbl_mirrored[i] = mir;
              tbl_size[i] = r.size_code;
              tbl_set_mode[i] = r.mode_code[0];
              tbl_value[i] = mv;
              tbl_enables[i] = 1'b1;
              rep.status = 1'b0;
              rep.entry_index = 6'(i);
              done = 1;
            end
        end
      end
      OP_REMOVE: begin
        if (r.slot < NUM_ENTRIES) begin
          for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (r.slot == 6'(i)) begin
              tbl_used[i] = 1'b0;
              tbl_base[i] = '0;
              tbl_mirrored[i] = 1'b0;
              tbl_size[i] = '0;
              tbl_set_mode[i] = 1'b0;
              tbl_value[i] = '0;
            end
          end
          tbl_enables[r.slot] = 1'b0;
        end
      end
      OP_SET_EN: tbl_enables = r.new_enables;
      OP_FILTER: rep.filtered_value = patch_write(r);
      OP_CLEAR:  clear_table();
      default: ;
    endcase
    rep.enables_now = tbl_enables;
    return rep;
  endfunction

  function automatic logic [167:0] pack_request(request_t r);
    return {8'h00, r.new_enables, r.slot, r.old_valid, r.old_value, r.data_value,
            r.mode_code, r.size_code, r.address, r.op};
  endfunction

  // Valid stays high from one transaction into the next unless an idle burst
  // comes between them.
  task automatic send_request(request_t r);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata <= pack_request(r);
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_replies.push_back(apply_request(r));
    if (r.op == OP_ADD) begin
      recent_addrs.push_back(r.address);
      if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
    end
  endtask

  function automatic request_t random_request();
    request_t r;
    r.op = 3'($urandom_range(0, 7));
    r.address = 24'($urandom);
    r.size_code = 2'($urandom);
    r.mode_code = 2'($urandom);
    r.data_value = $urandom;
    r.old_value = $urandom;
    r.old_valid = 1'($urandom);
    r.slot = 6'($urandom);
    r.new_enables = {$urandom, $urandom};
    return r;
  endfunction

  function automatic logic [23:0] near_address();
    logic [23:0] a;
    if (recent_addrs.size() == 0) return 24'($urandom);
    a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
    a = a + 24'($urandom_range(0, 6)) - 24'd3;
    // Hop to another mirror of the same window now and then.
    if (window_hit(a) && $urandom_range(0, 2) == 0) a[19:16] = 4'($urandom);
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (quiet) begin
        m_tready <= 1'b1;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        stall_left <= $urandom_range(0, 6);
      end else begin
        m_tready <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        reply_t got;
        reply_t want;
        got = m_tdata[102:0];
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          failed = 1;
        end else begin
          want = expected_replies.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %h actual %h", $time, want.status,
                     got.status);
            failed = 1;
          end
          if (got.entry_index !== want.entry_index) begin
            $display("%0t: entry_index expected %h actual %h", $time,
                     want.entry_index, got.entry_index);
            failed = 1;
          end
          if (got.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value expected %h actual %h", $time,
                     want.filtered_value, got.filtered_value);
            failed = 1;
          end
          if (got.enables_now !== want.enables_now) begin
            $display("%0t: enables_now expected %h actual %h", $time,
                     want.enables_now, got.enables_now);
            failed = 1;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    request_t r;
    r = '0;
    // Filter with an empty table passes the write through.
    r.op = OP_FILTER; r.address = 24'hffffff; r.size_code = 2'd2;
    r.data_value = 32'hffffffff; send_request(r);
    // Rejected adds: bad size, bad modes.
    r = '0; r.op = OP_ADD; r.size_code = 2'd3; send_request(r);
    r.size_code = 2'd0; r.mode_code = 2'd2; send_request(r);
    r.mode_code = 2'd3; send_request(r);
    // Mirrored set entry and a write through another mirror.
    r = '0; r.op = OP_ADD; r.address = 24'h1a1234; r.size_code = 2'd1;
    r.mode_code = 2'd1; r.data_value = 32'hdeadbeef; send_request(r);
    send_request(r);
    r = '0; r.op = OP_FILTER; r.address = 24'h151233; r.size_code = 2'd2;
    r.data_value = 32'h11223344; send_request(r);
    // Block entry at the top of memory, wrapping past 24 bits.
    r = '0; r.op = OP_ADD; r.address = 24'hffffff; r.size_code = 2'd2;
    r.data_value = 32'h01020304; send_request(r);
    r = '0; r.op = OP_FILTER; r.address = 24'hfffffe; r.size_code = 2'd2;
    r.data_value = 32'haabbccdd; r.old_value = 32'h55667788; r.old_valid = 1'b1;
    send_request(r);
    r.old_valid = 1'b0; send_request(r);
    r.size_code = 2'd3; send_request(r);
    r = '0; r.op = OP_ADD; r.address = 24'hdfffff; r.size_code = 2'd0;
    r.mode_code = 2'd1; r.data_value = 32'hffffffff; send_request(r);
    r = '0; r.op = OP_SET_EN; r.new_enables = 64'hffff_0000_0000_0000;
    send_request(r);
    r.op = OP_FILTER; r.address = 24'hd0ffff; r.data_value = 32'h12; send_request(r);
    r = '0; r.op = OP_SET_EN; r.new_enables = '1; send_request(r);
    r = '0; r.op = OP_REMOVE; r.slot = 6'd63; send_request(r);
    r.slot = 6'd0; send_request(r);
    r = '0; r.op = 3'd5; send_request(r);
    r.op = 3'd7; send_request(r);
    // Fill the table until it rejects.
    for (int i = 0; i < NUM_ENTRIES + 1; i++) begin
      r = '0; r.op = OP_ADD; r.address = 24'(i * 8); r.data_value = 32'(i);
      send_request(r);
    end
    r = '0; r.op = OP_CLEAR; send_request(r);
  endtask

  task automatic test_random(int count);
    request_t r;
    for (int i = 0; i < count; i++) begin
      r = random_request();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          r.op = OP_ADD;
          if ($urandom_range(0, 3) != 0) r.size_code = 2'($urandom_range(0, 2));
          if ($urandom_range(0, 3) != 0) r.mode_code = 2'($urandom_range(0, 1));
          if ($urandom_range(0, 2) == 0)
            r.address = {4'($urandom_range(0, 1) ? 4'h1 : 4'hd), 20'($urandom)};
        end
        3, 4, 5, 6: begin
          r.op = OP_FILTER;
          if ($urandom_range(0, 4) != 0) r.address = near_address();
        end
        7: r.op = OP_REMOVE;
        default: ;
      endcase
      if (r.op == OP_CLEAR && $urandom_range(0, 3) != 0) r.op = OP_FILTER;
      if (r.op == OP_SET_EN && $urandom_range(0, 1) == 0)
        r.new_enables = {32'($urandom), 16'hffff, 16'($urandom)} | 64'hffff;
      send_request(r);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    quiet = 0;
    clear_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(1300);
    quiet = 1;
    test_random(200);
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
